@@ hdl/wall_follow_pd_steering_defines.svh @@
// Assertion macros used by the port checker of the wall-follow steering block.
// Depends on nothing; every macro samples on i_clk and is quiet while i_rst_n is low.
`ifndef WALL_FOLLOW_PD_STEERING_DEFINES_SVH
`define WALL_FOLLOW_PD_STEERING_DEFINES_SVH

// Same-cycle implication.
`define WFPD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wall follow steering check failed");

// Next-cycle implication.
`define WFPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wall follow steering check failed");

`endif

@@ hdl/wfpd_pkg.sv @@
// Shared types and constants of the wall-follow PD steering block.
// Used by the top level and its port checker; depends on nothing.
`default_nettype none

package wfpd_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int GAIN_W      = 8;
    localparam int PERIOD_W    = 16;
    localparam int LEVEL_W     = 12;
    localparam int BAND_W      = 10;
    localparam int ERR_W       = 13;
    localparam int CORR_W      = 18;
    localparam int WALL_W      = 2;
    localparam int OUT_FIELD_W = 2 * PERIOD_W + CORR_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam int ERR_MIN  = -(1 << (ERR_W - 1));
    localparam int ERR_MAX  = (1 << (ERR_W - 1)) - 1;
    localparam int CORR_MIN = -(1 << (CORR_W - 1));
    localparam int CORR_MAX = (1 << (CORR_W - 1)) - 1;

    localparam logic [GAIN_W-1:0]   P_GAIN_RST       = 8'd11;
    localparam logic [GAIN_W-1:0]   D_GAIN_RST       = 8'd20;
    localparam logic [PERIOD_W-1:0] BASE_PERIOD_RST  = 16'd20000;
    localparam logic [LEVEL_W-1:0]  RIGHT_DETECT_RST = 12'd3100;
    localparam logic [LEVEL_W-1:0]  RIGHT_CENTER_RST = 12'd3250;
    localparam logic [LEVEL_W-1:0]  LEFT_DETECT_RST  = 12'd1500;
    localparam logic [LEVEL_W-1:0]  LEFT_CENTER_RST  = 12'd1850;
    localparam logic [BAND_W-1:0]   DEAD_BAND_RST    = 10'd20;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_P_GAIN       = 3'd0,
        CFG_D_GAIN       = 3'd1,
        CFG_BASE_PERIOD  = 3'd2,
        CFG_RIGHT_DETECT = 3'd3,
        CFG_RIGHT_CENTER = 3'd4,
        CFG_LEFT_DETECT  = 3'd5,
        CFG_LEFT_CENTER  = 3'd6,
        CFG_DEAD_BAND    = 3'd7
    } t_cfg_index;

    typedef enum logic [WALL_W-1:0] {
        WALL_NONE  = 2'd0,
        WALL_RIGHT = 2'd1,
        WALL_LEFT  = 2'd2
    } t_wall;

endpackage

`default_nettype wire

@@ hdl/wall_follow_pd_steering.sv @@
// Wall-follow PD steering: median-of-three sensor filter, wall select, PD correction, periods.
// Depends on wfpd_pkg.
//
// One request carries three right and three left wall-sensor samples; each side is reduced to
// its median, the usable wall sets the steering error, and a PD correction with a dead band
// trims the two motor periods around base_period. The datapath is a four-register pipeline
// (input, error, gain products, result): m_axis_tvalid rises once a request reaches the result
// register, and a new request is taken every cycle unless m_axis_tready holds the output.
// While a result waits, requests keep entering until all four registers hold one, then
// s_axis_tready drops. Write configuration only while idle.
`default_nettype none

module wall_follow_pd_steering
    import wfpd_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]                     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]                      i_cfg_data,
    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    // right_sample_a, right_sample_b, right_sample_c, left_sample_a, left_sample_b,
    // left_sample_c, zero fill
    input  logic [((6*SAMPLE_BITS+7)/8)*8-1:0]         s_axis_tdata,
    output logic                                       m_axis_tvalid,
    input  logic                                       m_axis_tready,
    // motor_one_period, motor_two_period, correction, zero fill
    output logic [OUT_TDATA_W-1:0]                     m_axis_tdata,
    // wall_used
    output logic [WALL_W-1:0]                          m_axis_tuser
);

    localparam int SB   = SAMPLE_BITS;
    localparam int CW   = (SB > LEVEL_W) ? SB : LEVEL_W;
    localparam int DW   = CW + 2;
    localparam int PW   = GAIN_W + 1 + ERR_W;
    localparam int DFW  = ERR_W + 1;
    localparam int QW   = GAIN_W + 1 + DFW;
    localparam int SW   = QW + 1;
    localparam int MW   = PERIOD_W + 4;

    localparam logic signed [DW-1:0] ERR_LO  = DW'(ERR_MIN);
    localparam logic signed [DW-1:0] ERR_HI  = DW'(ERR_MAX);
    localparam logic signed [SW-1:0] CORR_LO = SW'(CORR_MIN);
    localparam logic signed [SW-1:0] CORR_HI = SW'(CORR_MAX);

    // configuration
    logic [GAIN_W-1:0]   r_p_gain;
    logic [GAIN_W-1:0]   r_d_gain;
    logic [PERIOD_W-1:0] r_base_period;
    logic [LEVEL_W-1:0]  r_right_detect;
    logic [LEVEL_W-1:0]  r_right_center;
    logic [LEVEL_W-1:0]  r_left_detect;
    logic [LEVEL_W-1:0]  r_left_center;
    logic [BAND_W-1:0]   r_dead_band;

    // pipeline
    logic                    r1_vld, r2_vld, r3_vld, r4_vld;
    logic                    n1_vld, n2_vld, n3_vld, n4_vld;
    logic                    w_rdy2, w_rdy3, w_rdy4;
    logic                    w_load1, w_load2, w_load3, w_load4;
    logic [6*SB-1:0]         r1_samples;
    logic signed [ERR_W-1:0] r_prev_err;
    logic signed [ERR_W-1:0] r2_err;
    logic signed [DFW-1:0]   r2_diff;
    logic                    r2_zero;
    t_wall                   r2_wall;
    logic signed [PW-1:0]    r3_p;
    logic signed [QW-1:0]    r3_d;
    logic                    r3_zero;
    t_wall                   r3_wall;
    logic [PERIOD_W-1:0]     r4_m1;
    logic [PERIOD_W-1:0]     r4_m2;
    logic [CORR_W-1:0]       r4_corr;
    t_wall                   r4_wall;

    // error stage logic
    logic [SB-1:0]           w_ra, w_rb, w_rc, w_la, w_lb, w_lc;
    logic [SB-1:0]           w_rlo, w_rhi, w_llo, w_lhi, w_rmed, w_lmed;
    logic signed [DW-1:0]    w_raw, w_half, w_clip;
    logic signed [ERR_W-1:0] w_err;
    logic signed [DFW-1:0]   w_err_x, w_mag_x;
    t_wall                   w_wall;

    // result stage logic
    logic signed [SW-1:0]     w_sum, w_sat;
    logic signed [CORR_W-1:0] w_corr;
    logic signed [MW-1:0]     w_m1, w_m2;
    logic [PERIOD_W-1:0]      w_m1_sat, w_m2_sat;

    // handshake chain
    assign w_rdy4        = !r4_vld || m_axis_tready;
    assign w_rdy3        = !r3_vld || w_rdy4;
    assign w_rdy2        = !r2_vld || w_rdy3;
    assign s_axis_tready = !r1_vld || w_rdy2;
    assign w_load1       = s_axis_tvalid && s_axis_tready;
    assign w_load2       = r1_vld && w_rdy2;
    assign w_load3       = r2_vld && w_rdy3;
    assign w_load4       = r3_vld && w_rdy4;
    assign n1_vld        = w_load1 || (r1_vld && !w_rdy2);
    assign n2_vld        = w_load2 || (r2_vld && !w_rdy3);
    assign n3_vld        = w_load3 || (r3_vld && !w_rdy4);
    assign n4_vld        = w_load4 || (r4_vld && !m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_gain       <= P_GAIN_RST;
            r_d_gain       <= D_GAIN_RST;
            r_base_period  <= BASE_PERIOD_RST;
            r_right_detect <= RIGHT_DETECT_RST;
            r_right_center <= RIGHT_CENTER_RST;
            r_left_detect  <= LEFT_DETECT_RST;
            r_left_center  <= LEFT_CENTER_RST;
            r_dead_band    <= DEAD_BAND_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_P_GAIN:       r_p_gain       <= i_cfg_data[GAIN_W-1:0];
                CFG_D_GAIN:       r_d_gain       <= i_cfg_data[GAIN_W-1:0];
                CFG_BASE_PERIOD:  r_base_period  <= i_cfg_data[PERIOD_W-1:0];
                CFG_RIGHT_DETECT: r_right_detect <= i_cfg_data[LEVEL_W-1:0];
                CFG_RIGHT_CENTER: r_right_center <= i_cfg_data[LEVEL_W-1:0];
                CFG_LEFT_DETECT:  r_left_detect  <= i_cfg_data[LEVEL_W-1:0];
                CFG_LEFT_CENTER:  r_left_center  <= i_cfg_data[LEVEL_W-1:0];
                CFG_DEAD_BAND:    r_dead_band    <= i_cfg_data[BAND_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld     <= 1'b0;
            r2_vld     <= 1'b0;
            r3_vld     <= 1'b0;
            r4_vld     <= 1'b0;
            r_prev_err <= '0;
        end else begin
            r1_vld <= n1_vld;
            r2_vld <= n2_vld;
            r3_vld <= n3_vld;
            r4_vld <= n4_vld;
            if (w_load2) begin
                r_prev_err <= w_err;
            end
        end
    end

    // median of three per side
    assign w_ra   = r1_samples[0*SB +: SB];
    assign w_rb   = r1_samples[1*SB +: SB];
    assign w_rc   = r1_samples[2*SB +: SB];
    assign w_la   = r1_samples[3*SB +: SB];
    assign w_lb   = r1_samples[4*SB +: SB];
    assign w_lc   = r1_samples[5*SB +: SB];
    assign w_rlo  = (w_ra < w_rb) ? w_ra : w_rb;
    assign w_rhi  = (w_ra < w_rb) ? w_rb : w_ra;
    assign w_llo  = (w_la < w_lb) ? w_la : w_lb;
    assign w_lhi  = (w_la < w_lb) ? w_lb : w_la;
    assign w_rmed = (w_rc <= w_rlo) ? w_rlo : ((w_rc >= w_rhi) ? w_rhi : w_rc);
    assign w_lmed = (w_lc <= w_llo) ? w_llo : ((w_lc >= w_lhi) ? w_lhi : w_lc);

    always_comb begin
        w_wall = WALL_NONE;
        w_raw  = '0;
        if (CW'(w_rmed) > CW'(r_right_detect)) begin
            w_wall = WALL_RIGHT;
            w_raw  = $signed(DW'(w_rmed)) - $signed(DW'(r_right_center));
        end else if (CW'(w_lmed) > CW'(r_left_detect)) begin
            w_wall = WALL_LEFT;
            w_raw  = $signed(DW'(r_left_center)) - $signed(DW'(w_lmed));
        end
    end

    // halve toward zero, then limit to the error range
    assign w_half  = (w_raw + $signed(DW'(w_raw[DW-1]))) >>> 1;
    assign w_clip  = (w_half < ERR_LO) ? ERR_LO : ((w_half > ERR_HI) ? ERR_HI : w_half);
    assign w_err   = w_clip[ERR_W-1:0];
    assign w_err_x = DFW'(w_err);
    assign w_mag_x = w_err[ERR_W-1] ? -w_err_x : w_err_x;

    always_ff @(posedge i_clk) begin
        if (w_load1) begin
            r1_samples <= s_axis_tdata[6*SB-1:0];
        end
        if (w_load2) begin
            r2_err  <= w_err;
            r2_diff <= w_err_x - DFW'(r_prev_err);
            r2_zero <= w_mag_x[ERR_W-1:0] < ERR_W'(r_dead_band);
            r2_wall <= w_wall;
        end
        if (w_load3) begin
            r3_p    <= $signed({1'b0, r_p_gain}) * r2_err;
            r3_d    <= $signed({1'b0, r_d_gain}) * r2_diff;
            r3_zero <= r2_zero;
            r3_wall <= r2_wall;
        end
        if (w_load4) begin
            r4_m1   <= w_m1_sat;
            r4_m2   <= w_m2_sat;
            r4_corr <= w_corr;
            r4_wall <= r3_wall;
        end
    end

    // sum, limit, dead band, motor periods
    assign w_sum  = SW'(r3_p) + SW'(r3_d);
    assign w_sat  = (w_sum < CORR_LO) ? CORR_LO : ((w_sum > CORR_HI) ? CORR_HI : w_sum);
    assign w_corr = r3_zero ? '0 : w_sat[CORR_W-1:0];
    assign w_m1   = $signed(MW'(r_base_period)) - MW'(w_corr);
    assign w_m2   = $signed(MW'(r_base_period)) + MW'(w_corr);

    always_comb begin
        if (w_m1[MW-1]) begin
            w_m1_sat = '0;
        end else if (|w_m1[MW-2:PERIOD_W]) begin
            w_m1_sat = '1;
        end else begin
            w_m1_sat = w_m1[PERIOD_W-1:0];
        end
        if (w_m2[MW-1]) begin
            w_m2_sat = '0;
        end else if (|w_m2[MW-2:PERIOD_W]) begin
            w_m2_sat = '1;
        end else begin
            w_m2_sat = w_m2[PERIOD_W-1:0];
        end
    end

    assign m_axis_tvalid = r4_vld;
    assign m_axis_tdata  = OUT_TDATA_W'({r4_corr, r4_m2, r4_m1});
    assign m_axis_tuser  = r4_wall;

endmodule

`default_nettype wire

@@ hdl/wfpd_checker.sv @@
// Port-level checks on the result stream of the wall-follow steering block, bound to the top.
// Depends on wfpd_pkg and wall_follow_pd_steering_defines.svh.
`default_nettype none
`include "wall_follow_pd_steering_defines.svh"

module wfpd_checker
    import wfpd_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [WALL_W-1:0]      m_axis_tuser
);

    logic [PERIOD_W-1:0] w_m1;
    logic [PERIOD_W-1:0] w_m2;
    logic [CORR_W-1:0]   w_corr;

    assign w_m1   = m_axis_tdata[PERIOD_W-1:0];
    assign w_m2   = m_axis_tdata[2*PERIOD_W-1:PERIOD_W];
    assign w_corr = m_axis_tdata[2*PERIOD_W+CORR_W-1:2*PERIOD_W];

    `WFPD_ASSERT_NEXT(a_hold_stalled, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `WFPD_ASSERT_NOW(a_wall_code, m_axis_tvalid,
        m_axis_tuser == WALL_NONE || m_axis_tuser == WALL_RIGHT || m_axis_tuser == WALL_LEFT)
    `WFPD_ASSERT_NOW(a_zero_even, m_axis_tvalid && w_corr == '0, w_m1 == w_m2)
    `WFPD_ASSERT_NOW(a_sign_order, m_axis_tvalid,
        (w_corr[CORR_W-1] && w_m1 >= w_m2) || (!w_corr[CORR_W-1] && w_m1 <= w_m2))

endmodule

bind wall_follow_pd_steering wfpd_checker u_wfpd_checker (.*);

`default_nettype wire

@@ test/wfpd_steering_checker.sv @@
// Scoreboard for the wall-follow PD steering block: tracks register writes, predicts one
// result per accepted request and compares it with the block's output stream.
// Depends on wfpd_pkg.
module wfpd_steering_checker
    import wfpd_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]             i_cfg_index,
    input  logic [CFG_DATA_W-1:0]              i_cfg_data,
    input  logic                               i_s_axis_tvalid,
    input  logic                               i_s_axis_tready,
    input  logic [((6*SAMPLE_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    input  logic                               i_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    input  logic [OUT_TDATA_W-1:0]             i_m_axis_tdata,
    input  logic [WALL_W-1:0]                  i_m_axis_tuser,
    output int                                 o_pending,
    output int                                 o_fail_count
);

    localparam int SB = SAMPLE_BITS;

    typedef struct packed {
        logic [PERIOD_W-1:0]      motor_one;
        logic [PERIOD_W-1:0]      motor_two;
        logic signed [CORR_W-1:0] correction;
        t_wall                    wall;
    } t_steering;

    logic [GAIN_W-1:0]   p_gain_q;
    logic [GAIN_W-1:0]   d_gain_q;
    logic [PERIOD_W-1:0] base_q;
    logic [LEVEL_W-1:0]  r_detect_q;
    logic [LEVEL_W-1:0]  r_center_q;
    logic [LEVEL_W-1:0]  l_detect_q;
    logic [LEVEL_W-1:0]  l_center_q;
    logic [BAND_W-1:0]   band_q;
    int                  last_error;
    t_steering           pending_steering[$];
    int                  mismatches = 0;

    assign o_fail_count = mismatches;

    task automatic report_mismatch(input string what, input longint want, input longint got);
        $display("MISMATCH at %0t %s: expected %0d, got %0d", $realtime, what, want, got);
        mismatches++;
    endtask

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [SB-1:0] median_of_three(input logic [SB-1:0] a,
                                                      input logic [SB-1:0] b,
                                                      input logic [SB-1:0] c);
        logic [SB-1:0] lo;
        logic [SB-1:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c <= lo) return lo;
        if (c >= hi) return hi;
        return c;
    endfunction

    function automatic t_steering compute_steering(input logic [6*SB-1:0] samples,
                                                   input int prev, output int err);
        logic [SB-1:0] r_med;
        logic [SB-1:0] l_med;
        longint        sum;
        t_steering     res;
        r_med = median_of_three(samples[0 +: SB], samples[SB +: SB], samples[2*SB +: SB]);
        l_med = median_of_three(samples[3*SB +: SB], samples[4*SB +: SB], samples[5*SB +: SB]);
        err = 0;
        res.wall = WALL_NONE;
        if (r_med > r_detect_q) begin
            err = (int'(r_med) - int'(r_center_q)) / 2;
            res.wall = WALL_RIGHT;
        end else if (l_med > l_detect_q) begin
            err = (int'(l_center_q) - int'(l_med)) / 2;
            res.wall = WALL_LEFT;
        end
        err = int'(clamp(err, ERR_MIN, ERR_MAX));
        sum = longint'(p_gain_q) * err + longint'(d_gain_q) * (err - prev);
        sum = clamp(sum, CORR_MIN, CORR_MAX);
        if ((err < 0 ? -err : err) < int'(band_q)) sum = 0;
        res.correction = sum[CORR_W-1:0];
        res.motor_one = PERIOD_W'(clamp(longint'(base_q) - sum, 0, 65535));
        res.motor_two = PERIOD_W'(clamp(longint'(base_q) + sum, 0, 65535));
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_steering got;
        t_steering want;
        int        err;
        if (!i_rst_n) begin
            p_gain_q   = P_GAIN_RST;
            d_gain_q   = D_GAIN_RST;
            base_q     = BASE_PERIOD_RST;
            r_detect_q = RIGHT_DETECT_RST;
            r_center_q = RIGHT_CENTER_RST;
            l_detect_q = LEFT_DETECT_RST;
            l_center_q = LEFT_CENTER_RST;
            band_q     = DEAD_BAND_RST;
            last_error = 0;
            pending_steering.delete();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.motor_one  = i_m_axis_tdata[0 +: PERIOD_W];
                got.motor_two  = i_m_axis_tdata[PERIOD_W +: PERIOD_W];
                got.correction = i_m_axis_tdata[2*PERIOD_W +: CORR_W];
                got.wall       = t_wall'(i_m_axis_tuser);
                if (pending_steering.size() == 0) begin
                    report_mismatch("result with nothing pending", 0, 0);
                end else begin
                    want = pending_steering.pop_front();
                    if (got.motor_one !== want.motor_one)
                        report_mismatch("motor_one_period", want.motor_one, got.motor_one);
                    if (got.motor_two !== want.motor_two)
                        report_mismatch("motor_two_period", want.motor_two, got.motor_two);
                    if (got.correction !== want.correction)
                        report_mismatch("correction", want.correction, got.correction);
                    if (got.wall !== want.wall)
                        report_mismatch("wall_used", want.wall, got.wall);
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                want = compute_steering(i_s_axis_tdata[6*SB-1:0], last_error, err);
                last_error = err;
                pending_steering.push_back(want);
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_P_GAIN:       p_gain_q   = i_cfg_data[GAIN_W-1:0];
                    CFG_D_GAIN:       d_gain_q   = i_cfg_data[GAIN_W-1:0];
                    CFG_BASE_PERIOD:  base_q     = i_cfg_data[PERIOD_W-1:0];
                    CFG_RIGHT_DETECT: r_detect_q = i_cfg_data[LEVEL_W-1:0];
                    CFG_RIGHT_CENTER: r_center_q = i_cfg_data[LEVEL_W-1:0];
                    CFG_LEFT_DETECT:  l_detect_q = i_cfg_data[LEVEL_W-1:0];
                    CFG_LEFT_CENTER:  l_center_q = i_cfg_data[LEVEL_W-1:0];
                    CFG_DEAD_BAND:    band_q     = i_cfg_data[BAND_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending = pending_steering.size();
    end

endmodule

@@ test/testbench.sv @@
// Top of the wall-follow PD steering testbench: clock, reset, register phases, request and
// result stream drivers with random gaps, and the final verdict.
// Depends on wfpd_pkg, wall_follow_pd_steering and wfpd_steering_checker.
module testbench;
    import wfpd_pkg::*;

    localparam int SAMPLE_BITS     = 12;
    localparam int SB              = SAMPLE_BITS;
    localparam int S_TDATA_W       = ((6*SAMPLE_BITS+7)/8)*8;
    localparam int LEVEL_MAX       = (1 << SAMPLE_BITS) - 1;
    localparam int PRESSURE_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 8;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [WALL_W-1:0]      m_axis_tuser;
    int                     pending;
    int                     fail_count;
    logic [CFG_DATA_W-1:0]  cfg_now [8];
    bit                     pressure_req = 1'b0;
    bit                     sender_calm = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    wall_follow_pd_steering #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    wfpd_steering_checker #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_s_axis_tvalid(s_axis_tvalid),
        .i_s_axis_tready(s_axis_tready),
        .i_s_axis_tdata (s_axis_tdata),
        .i_m_axis_tvalid(m_axis_tvalid),
        .i_m_axis_tready(m_axis_tready),
        .i_m_axis_tdata (m_axis_tdata),
        .i_m_axis_tuser (m_axis_tuser),
        .o_pending      (pending),
        .o_fail_count   (fail_count)
    );

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack(input int ra, input int rb, input int rc,
                                                  input int la, input int lb, input int lc);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[0 +: SB]    = SB'(ra);
        d[SB +: SB]   = SB'(rb);
        d[2*SB +: SB] = SB'(rc);
        d[3*SB +: SB] = SB'(la);
        d[4*SB +: SB] = SB'(lb);
        d[5*SB +: SB] = SB'(lc);
        return d;
    endfunction

    function automatic int jitter(input int level, input int spread);
        int v;
        v = level - spread + int'($urandom_range(0, 2*spread));
        if (v < 0) v = 0;
        if (v > LEVEL_MAX) v = LEVEL_MAX;
        return v;
    endfunction

    function automatic int near_center(input int center);
        int off;
        off = $urandom_range(0, 2*int'(cfg_now[CFG_DEAD_BAND]) + 3);
        return $urandom_range(0, 1) ? center + off : center - off;
    endfunction

    function automatic logic [3*SB-1:0] sensor_triple(input int level, input int spread);
        int s [3];
        for (int k = 0; k < 3; k++) s[k] = jitter(level, spread);
        if ($urandom_range(0, 5) == 0) s[$urandom_range(0, 2)] = $urandom_range(0, LEVEL_MAX);
        return {s[2][SB-1:0], s[1][SB-1:0], s[0][SB-1:0]};
    endfunction

    function automatic logic [S_TDATA_W-1:0] random_request();
        logic [S_TDATA_W-1:0] d;
        int                   mode;
        int                   r_lvl;
        int                   l_lvl;
        int                   spread;
        d = '0;
        mode = $urandom_range(0, 9);
        spread = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(0, 400);
        r_lvl = $urandom_range(0, LEVEL_MAX);
        l_lvl = $urandom_range(0, LEVEL_MAX);
        if (mode <= 3) begin
            r_lvl = $urandom_range(0, 2) == 0 ? near_center(cfg_now[CFG_RIGHT_CENTER])
                                              : $urandom_range(cfg_now[CFG_RIGHT_DETECT],
                                                               LEVEL_MAX);
        end else if (mode <= 6) begin
            r_lvl = $urandom_range(0, cfg_now[CFG_RIGHT_DETECT]);
            l_lvl = $urandom_range(0, 2) == 0 ? near_center(cfg_now[CFG_LEFT_CENTER])
                                              : $urandom_range(cfg_now[CFG_LEFT_DETECT],
                                                               LEVEL_MAX);
        end else if (mode == 9) begin
            r_lvl = int'(cfg_now[CFG_RIGHT_DETECT]) + $urandom_range(0, 4) - 2;
            l_lvl = int'(cfg_now[CFG_LEFT_DETECT]) + $urandom_range(0, 4) - 2;
            spread = 0;
        end
        if (mode == 7) begin
            for (int k = 0; k < 6; k++) d[k*SB +: SB] = SB'($urandom_range(0, LEVEL_MAX));
        end else if (mode == 8) begin
            for (int k = 0; k < 6; k++) d[k*SB +: SB] = $urandom_range(0, 1) ? '1 : '0;
        end else begin
            d[0 +: 3*SB]    = sensor_triple(r_lvl, spread);
            d[3*SB +: 3*SB] = sensor_triple(l_lvl, spread);
        end
        return d;
    endfunction

    task automatic send_request(input logic [S_TDATA_W-1:0] data);
        int gap;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if ($urandom_range(0, 31) == 0) sender_calm = !sender_calm;
        gap = (sender_calm || $urandom_range(0, 1)) ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_random(input int count);
        repeat (count) send_request(random_request());
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        cfg_now[idx] = val;
    endtask

    task automatic apply_config(input int p, input int d, input int base,
                                input int r_det, input int r_cen,
                                input int l_det, input int l_cen, input int band);
        write_reg(CFG_P_GAIN, CFG_DATA_W'(p));
        write_reg(CFG_D_GAIN, CFG_DATA_W'(d));
        write_reg(CFG_BASE_PERIOD, CFG_DATA_W'(base));
        write_reg(CFG_RIGHT_DETECT, CFG_DATA_W'(r_det));
        write_reg(CFG_RIGHT_CENTER, CFG_DATA_W'(r_cen));
        write_reg(CFG_LEFT_DETECT, CFG_DATA_W'(l_det));
        write_reg(CFG_LEFT_CENTER, CFG_DATA_W'(l_cen));
        write_reg(CFG_DEAD_BAND, CFG_DATA_W'(band));
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin : receiver
        int  gap;
        bit  calm;
        m_axis_tready = 1'b0;
        gap = 0;
        calm = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (pressure_req) begin
                pressure_req = 1'b0;
                gap = PRESSURE_CYCLES;
            end
            if ($urandom_range(0, 63) == 0) calm = !calm;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                gap--;
            end else begin
                m_axis_tready <= 1'b1;
                if (!calm && $urandom_range(0, 2) == 0) gap = pick_gap();
            end
        end
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_now[CFG_P_GAIN]       = P_GAIN_RST;
        cfg_now[CFG_D_GAIN]       = D_GAIN_RST;
        cfg_now[CFG_BASE_PERIOD]  = BASE_PERIOD_RST;
        cfg_now[CFG_RIGHT_DETECT] = RIGHT_DETECT_RST;
        cfg_now[CFG_RIGHT_CENTER] = RIGHT_CENTER_RST;
        cfg_now[CFG_LEFT_DETECT]  = LEFT_DETECT_RST;
        cfg_now[CFG_LEFT_CENTER]  = LEFT_CENTER_RST;
        cfg_now[CFG_DEAD_BAND]    = DEAD_BAND_RST;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: no wall, both walls, median picks, thresholds, dead band edges
        send_request(pack(0, 0, 0, 0, 0, 0));
        send_request(pack(4095, 4095, 4095, 4095, 4095, 4095));
        send_request(pack(3101, 0, 4095, 0, 0, 0));
        send_request(pack(0, 3101, 4095, 0, 0, 0));
        send_request(pack(4095, 0, 3101, 0, 0, 0));
        send_request(pack(3101, 4095, 0, 0, 0, 0));
        send_request(pack(0, 4095, 3300, 4095, 4095, 4095));
        send_request(pack(3100, 3100, 3100, 1501, 1501, 1501));
        send_request(pack(3100, 3100, 3100, 1500, 1500, 1500));
        send_request(pack(3290, 3290, 3290, 0, 0, 0));
        send_request(pack(3289, 3289, 3289, 0, 0, 0));
        send_request(pack(3209, 3209, 3209, 0, 0, 0));
        send_request(pack(3211, 3211, 3211, 0, 0, 0));
        send_request(pack(0, 0, 0, 0, 0, 0));
        send_request(pack(0, 0, 0, 4095, 4095, 4095));
        send_request(pack(0, 0, 0, 1851, 1851, 1851));
        send_request(pack(0, 0, 0, 1810, 1810, 1810));
        send_request(pack(0, 0, 0, 1811, 1811, 1811));
        send_request(pack(0, 0, 0, 4095, 0, 1700));
        send_request(pack(0, 0, 0, 1700, 4095, 0));
        send_request(pack(4095, 4095, 0, 0, 4095, 4095));
        send_random(80);
        wait_idle();

        apply_config(0, 0, 0, 0, 0, 0, 0, 0);
        send_random(60);
        wait_idle();

        apply_config(255, 255, 65535, 4095, 4095, 4095, 4095, 1023);
        send_random(40);
        wait_idle();

        apply_config(255, 255, 0, 2048, 2048, 2048, 2048, 0);
        pressure_req = 1'b1;
        send_random(80);
        wait_idle();

        apply_config(255, 255, 65535, 1000, 4095, 1000, 0, 0);
        send_random(80);
        wait_idle();

        apply_config($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 65535),
                     $urandom_range(2500, 4000), $urandom_range(2500, 4095),
                     $urandom_range(1000, 2500), $urandom_range(1000, 2500),
                     $urandom_range(0, 64));
        send_random(70);
        wait_idle();

        apply_config($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 65535),
                     $urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(0, 1023));
        send_random(70);
        wait_idle();

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
